// ===== rtl/core/index_pool_allocator_core_defines.svh =====
// assertion macros for the index pool allocator core
// used by the top level, expects clk and rst in scope
`ifndef INDEX_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define INDEX_POOL_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IPA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define IPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ipa_pkg.sv =====
// shared types and constants for the index pool allocator core
// no dependencies
package ipa_pkg;

  localparam int IDX_W          = 12;
  localparam int LIMIT_W        = 13;
  localparam int OP_W           = 3;
  localparam int STATUS_W       = 2;
  localparam int POOL_DEPTH_DEF = 4096;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 3'd0,
    OP_REL_NOW   = 3'd1,
    OP_REL_DEFER = 3'd2,
    OP_FLUSH     = 3'd3,
    OP_RESET     = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic finish;
    logic load_out;
  } ipa_cmd_t;

  typedef struct packed {
    logic needs_read;
  } ipa_sts_t;

endpackage

// ===== rtl/core/ipa_stack_ram.sv =====
// one-write one-read stack memory with registered read data
// uses ipa_pkg for the entry width
module ipa_stack_ram #(
  parameter int DEPTH = ipa_pkg::POOL_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [ipa_pkg::IDX_W-1:0]  wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [ipa_pkg::IDX_W-1:0]  rdata
);

  logic [ipa_pkg::IDX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ipa_datapath.sv =====
// datapath: counts, fresh counter, limit register, both stacks, result registers
// uses ipa_pkg and ipa_stack_ram
module ipa_datapath #(
  parameter int POOL_DEPTH = ipa_pkg::POOL_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ipa_pkg::ipa_cmd_t             cmd,
  output ipa_pkg::ipa_sts_t             sts,
  input  logic [ipa_pkg::OP_W-1:0]      opcode,
  input  logic [ipa_pkg::IDX_W-1:0]     slot_index,
  input  logic                          cfg_we,
  input  logic [ipa_pkg::LIMIT_W-1:0]   cfg_wdata,
  output logic [ipa_pkg::IDX_W-1:0]     granted_index,
  output logic [ipa_pkg::STATUS_W-1:0]  status,
  output logic                          deferred_empty
);

  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int ADDR_W = $clog2(POOL_DEPTH);
  localparam int LW     = (ipa_pkg::LIMIT_W > CNT_W) ? ipa_pkg::LIMIT_W : CNT_W;

  ipa_pkg::op_t               op_q;
  logic [ipa_pkg::IDX_W-1:0]  idx_q;
  logic [ipa_pkg::LIMIT_W-1:0] pool_limit;

  logic [CNT_W-1:0] dcount, dcount_next, d_pop;
  logic [CNT_W-1:0] fcount, fcount_next, f_pop;
  logic [ipa_pkg::LIMIT_W-1:0] fresh, fresh_next;
  logic [ipa_pkg::IDX_W-1:0] res_idx, res_idx_next;
  ipa_pkg::status_t          res_st, res_st_next;
  logic                      from_def, from_def_next;

  logic                      d_we, d_re, f_we, f_re;
  logic [ADDR_W-1:0]         d_waddr, d_raddr, f_waddr, f_raddr;
  logic [ipa_pkg::IDX_W-1:0] d_wdata, f_wdata, d_rdata, f_rdata, rd_word;

  logic          d_empty, f_empty, d_full, f_full, fresh_ok;
  logic [LW-1:0] lim_ext, eff_limit;

  assign d_pop   = dcount - CNT_W'(1);
  assign f_pop   = fcount - CNT_W'(1);
  assign d_empty = (dcount == '0);
  assign f_empty = (fcount == '0);
  assign d_full  = (dcount == CNT_W'(POOL_DEPTH));
  assign f_full  = (fcount == CNT_W'(POOL_DEPTH));

  // fresh indices stop below min(pool_limit, depth)
  assign lim_ext   = LW'(pool_limit);
  assign eff_limit = (lim_ext > LW'(POOL_DEPTH)) ? LW'(POOL_DEPTH) : lim_ext;
  assign fresh_ok  = (LW'(fresh) < eff_limit);

  assign rd_word = from_def ? d_rdata : f_rdata;

  always_comb begin
    dcount_next   = dcount;
    fcount_next   = fcount;
    fresh_next    = fresh;
    res_idx_next  = res_idx;
    res_st_next   = res_st;
    from_def_next = from_def;
    d_we    = 1'b0;
    d_re    = 1'b0;
    d_waddr = dcount[ADDR_W-1:0];
    d_raddr = d_pop[ADDR_W-1:0];
    d_wdata = idx_q;
    f_we    = 1'b0;
    f_re    = 1'b0;
    f_waddr = fcount[ADDR_W-1:0];
    f_raddr = f_pop[ADDR_W-1:0];
    f_wdata = idx_q;
    sts.needs_read = 1'b0;

    if (cmd.exec) begin
      res_idx_next = '0;
      res_st_next  = ipa_pkg::ST_OK;
      unique case (op_q)
        ipa_pkg::OP_ALLOC: begin
          if (!d_empty) begin
            dcount_next    = d_pop;
            d_re           = 1'b1;
            from_def_next  = 1'b1;
            sts.needs_read = 1'b1;
          end else if (!f_empty) begin
            fcount_next    = f_pop;
            f_re           = 1'b1;
            from_def_next  = 1'b0;
            sts.needs_read = 1'b1;
          end else if (fresh_ok) begin
            res_idx_next = fresh[ipa_pkg::IDX_W-1:0];
            fresh_next   = fresh + ipa_pkg::LIMIT_W'(1);
          end else begin
            res_st_next = ipa_pkg::ST_EMPTY;
          end
        end
        ipa_pkg::OP_REL_NOW: begin
          if (idx_q == '0 || f_full) begin
            res_st_next = ipa_pkg::ST_IGNORED;
          end else begin
            f_we        = 1'b1;
            fcount_next = fcount + CNT_W'(1);
          end
        end
        ipa_pkg::OP_REL_DEFER: begin
          if (idx_q == '0 || d_full) begin
            res_st_next = ipa_pkg::ST_IGNORED;
          end else begin
            d_we        = 1'b1;
            dcount_next = dcount + CNT_W'(1);
          end
        end
        ipa_pkg::OP_FLUSH: begin
          if (d_empty) begin
            res_st_next = ipa_pkg::ST_EMPTY;
          end else begin
            dcount_next    = d_pop;
            d_re           = 1'b1;
            from_def_next  = 1'b1;
            sts.needs_read = 1'b1;
          end
        end
        ipa_pkg::OP_RESET: begin
          dcount_next = '0;
          fcount_next = '0;
          fresh_next  = ipa_pkg::LIMIT_W'(1);
        end
        default: begin
          res_st_next = ipa_pkg::ST_EMPTY;
        end
      endcase
    end else if (cmd.finish) begin
      res_idx_next = rd_word;
      // flush moves the popped index onto the free stack if there is room
      if (op_q == ipa_pkg::OP_FLUSH) begin
        if (f_full) begin
          res_st_next = ipa_pkg::ST_IGNORED;
        end else begin
          f_we        = 1'b1;
          f_wdata     = rd_word;
          fcount_next = fcount + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcount     <= '0;
      fcount     <= '0;
      fresh      <= ipa_pkg::LIMIT_W'(1);
      pool_limit <= ipa_pkg::LIMIT_RESET;
    end else begin
      dcount <= dcount_next;
      fcount <= fcount_next;
      fresh  <= fresh_next;
      if (cfg_we) begin
        pool_limit <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= ipa_pkg::op_t'(opcode);
      idx_q <= slot_index;
    end
    res_idx  <= res_idx_next;
    res_st   <= res_st_next;
    from_def <= from_def_next;
    if (cmd.load_out) begin
      granted_index  <= res_idx;
      status         <= res_st;
      deferred_empty <= d_empty;
    end
  end

  ipa_stack_ram #(.DEPTH(POOL_DEPTH)) u_deferred_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  ipa_stack_ram #(.DEPTH(POOL_DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

endmodule

// ===== rtl/core/ipa_ctrl.sv =====
// controller state machine: input handshake, sequencing, output valid
// uses ipa_pkg
module ipa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ipa_pkg::ipa_sts_t sts,
  output ipa_pkg::ipa_cmd_t cmd
);

  ipa_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ipa_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = ipa_pkg::S_EXEC;
        end
      end
      ipa_pkg::S_EXEC: begin
        state_next = sts.needs_read ? ipa_pkg::S_READ : ipa_pkg::S_DONE;
      end
      ipa_pkg::S_READ: begin
        state_next = ipa_pkg::S_DONE;
      end
      ipa_pkg::S_DONE: begin
        if (out_free) begin
          state_next = ipa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ipa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ipa_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ipa_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      ipa_pkg::S_READ: begin
        cmd.finish = 1'b1;
      end
      ipa_pkg::S_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ipa_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/index_pool_allocator_core.sv =====
// index pool allocator: after acceptance a transaction goes through exec, then read when a stack is
// popped (registered ram read), then done, which loads the result register and sets out_valid
// one transaction at a time; done waits while the output register is still full and stalled
// an input is taken while the previous result still waits in the output register
// rst is synchronous: counts cleared, fresh counter 1, pool_limit 4096, stack ram not cleared
module index_pool_allocator_core #(
  parameter int POOL_DEPTH = ipa_pkg::POOL_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ipa_pkg::OP_W-1:0]      opcode,
  input  logic [ipa_pkg::IDX_W-1:0]     slot_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ipa_pkg::IDX_W-1:0]     granted_index,
  output logic [ipa_pkg::STATUS_W-1:0]  status,
  output logic                          deferred_empty,
  input  logic                          cfg_we,
  input  logic [ipa_pkg::LIMIT_W-1:0]   cfg_wdata
);

  `include "index_pool_allocator_core_defines.svh"

  ipa_pkg::ipa_cmd_t cmd;
  ipa_pkg::ipa_sts_t sts;

  ipa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ipa_datapath #(.POOL_DEPTH(POOL_DEPTH)) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .opcode         (opcode),
    .slot_index     (slot_index),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .granted_index  (granted_index),
    .status         (status),
    .deferred_empty (deferred_empty)
  );

  `IPA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `IPA_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid, "result load lost")
  `IPA_ASSERT_IMPL(a_fail_zero_index, out_valid && status == ipa_pkg::ST_EMPTY,
                   granted_index == '0, "failure with nonzero index")

endmodule

// ===== tb/sv/tb_index_pool_allocator_core.sv =====
// self-checking testbench for index_pool_allocator_core: directed table, then random traffic
// with bursty input and a stalling output, results checked against the table or a shadow pool
// depends on ipa_pkg and the core's port list only
module tb_index_pool_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH            = ipa_pkg::POOL_DEPTH_DEF;
  localparam int RESET_CYCLES     = 11;
  localparam int DIR_COUNT        = 25;
  localparam int SEGMENTS         = 10;
  localparam int SEG_ITEMS        = 142;
  localparam int TAIL_CYCLES      = 16;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int LONG_HOLD_AFTER  = 300;
  localparam int REPORT_LIMIT     = 10;

  localparam logic [ipa_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [ipa_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [ipa_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [ipa_pkg::IDX_W-1:0] granted;
    ipa_pkg::status_t          status;
    logic                      def_empty;
  } reply_t;

  typedef struct packed {
    logic [ipa_pkg::OP_W-1:0]  op;
    logic [ipa_pkg::IDX_W-1:0] idx;
    logic                      typed;
    reply_t                    reply;
  } dir_row_t;

  // run with pool_limit 4, so fresh indices are 1..3
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{ipa_pkg::OP_ALLOC,     12'd0,    1'b1, '{12'd1,    ipa_pkg::ST_OK,      1'b1}},
    '{ipa_pkg::OP_ALLOC,     12'd4095, 1'b1, '{12'd2,    ipa_pkg::ST_OK,      1'b1}},
    '{ipa_pkg::OP_ALLOC,     12'd0,    1'b1, '{12'd3,    ipa_pkg::ST_OK,      1'b1}},
    // pool exhausted
    '{ipa_pkg::OP_ALLOC,     12'd0,    1'b1, '{12'd0,    ipa_pkg::ST_EMPTY,   1'b1}},
    // zero index
    '{ipa_pkg::OP_REL_NOW,   12'd0,    1'b1, '{12'd0,    ipa_pkg::ST_IGNORED, 1'b1}},
    '{ipa_pkg::OP_REL_DEFER, 12'd0,    1'b1, '{12'd0,    ipa_pkg::ST_IGNORED, 1'b1}},
    // nothing deferred
    '{ipa_pkg::OP_FLUSH,     12'd0,    1'b1, '{12'd0,    ipa_pkg::ST_EMPTY,   1'b1}},
    '{ipa_pkg::OP_REL_NOW,   12'd4095, 1'b1, '{12'd0,    ipa_pkg::ST_OK,      1'b1}},
    '{ipa_pkg::OP_REL_NOW,   12'd2,    1'b1, '{12'd0,    ipa_pkg::ST_OK,      1'b1}},
    '{ipa_pkg::OP_REL_DEFER, 12'd4095, 1'b1, '{12'd0,    ipa_pkg::ST_OK,      1'b0}},
    '{ipa_pkg::OP_REL_DEFER, 12'd1,    1'b1, '{12'd0,    ipa_pkg::ST_OK,      1'b0}},
    // deferred stack first
    '{ipa_pkg::OP_ALLOC,     12'd0,    1'b1, '{12'd1,    ipa_pkg::ST_OK,      1'b0}},
    '{ipa_pkg::OP_FLUSH,     12'd0,    1'b1, '{12'd4095, ipa_pkg::ST_OK,      1'b1}},
    // then free stack
    '{ipa_pkg::OP_ALLOC,     12'd0,    1'b1, '{12'd4095, ipa_pkg::ST_OK,      1'b1}},
    '{ipa_pkg::OP_ALLOC,     12'd0,    1'b1, '{12'd2,    ipa_pkg::ST_OK,      1'b1}},
    '{ipa_pkg::OP_ALLOC,     12'd0,    1'b1, '{12'd4095, ipa_pkg::ST_OK,      1'b1}},
    '{ipa_pkg::OP_ALLOC,     12'd0,    1'b1, '{12'd0,    ipa_pkg::ST_EMPTY,   1'b1}},
    '{OP_SPARE_5,            12'd2730, 1'b1, '{12'd0,    ipa_pkg::ST_EMPTY,   1'b1}},
    '{OP_SPARE_6,            12'd1365, 1'b1, '{12'd0,    ipa_pkg::ST_EMPTY,   1'b1}},
    '{OP_SPARE_7,            12'd4095, 1'b1, '{12'd0,    ipa_pkg::ST_EMPTY,   1'b1}},
    '{ipa_pkg::OP_REL_DEFER, 12'd7,    1'b1, '{12'd0,    ipa_pkg::ST_OK,      1'b0}},
    '{ipa_pkg::OP_RESET,     12'd0,    1'b1, '{12'd0,    ipa_pkg::ST_OK,      1'b1}},
    // fresh counter restarts
    '{ipa_pkg::OP_ALLOC,     12'd0,    1'b1, '{12'd1,    ipa_pkg::ST_OK,      1'b1}},
    '{ipa_pkg::OP_REL_NOW,   12'd2048, 1'b0, '{12'd0,    ipa_pkg::ST_OK,      1'b0}},
    '{ipa_pkg::OP_ALLOC,     12'd0,    1'b0, '{12'd0,    ipa_pkg::ST_OK,      1'b0}}
  };

  logic                         clk        = 1'b0;
  logic                         rst        = 1'b1;
  logic                         in_valid   = 1'b0;
  logic                         in_ready;
  logic [ipa_pkg::OP_W-1:0]     opcode     = '0;
  logic [ipa_pkg::IDX_W-1:0]    slot_index = '0;
  logic                         out_valid;
  logic                         out_ready  = 1'b0;
  logic [ipa_pkg::IDX_W-1:0]    granted_index;
  logic [ipa_pkg::STATUS_W-1:0] status;
  logic                         deferred_empty;
  logic                         cfg_we     = 1'b0;
  logic [ipa_pkg::LIMIT_W-1:0]  cfg_wdata  = '0;

  // shadow copy of the pool
  logic [ipa_pkg::IDX_W-1:0]    shadow_deferred [DEPTH];
  logic [ipa_pkg::IDX_W-1:0]    shadow_free [DEPTH];
  int unsigned                  shadow_defer_cnt  = 0;
  int unsigned                  shadow_free_cnt   = 0;
  int unsigned                  shadow_next_fresh = 1;
  logic [ipa_pkg::LIMIT_W-1:0]  shadow_limit      = ipa_pkg::LIMIT_RESET;

  reply_t                       pending_replies [$];
  logic [ipa_pkg::IDX_W-1:0]    held_slots [$];
  int                           err_count       = 0;
  int                           result_count    = 0;
  int                           burst_left      = 0;
  bit                           long_hold_armed = 1'b1;

  index_pool_allocator_core #(
    .POOL_DEPTH(DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .slot_index    (slot_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_index (granted_index),
    .status        (status),
    .deferred_empty(deferred_empty),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_replies.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic reply_t predict_pool_reply(input logic [ipa_pkg::OP_W-1:0] op,
                                                input logic [ipa_pkg::IDX_W-1:0] idx);
    reply_t      r;
    int unsigned lim;
    r   = '{granted: '0, status: ipa_pkg::ST_OK, def_empty: 1'b0};
    lim = (shadow_limit > DEPTH) ? DEPTH : shadow_limit;
    case (op)
      ipa_pkg::OP_ALLOC: begin
        if (shadow_defer_cnt > 0) begin
          shadow_defer_cnt--;
          r.granted = shadow_deferred[shadow_defer_cnt];
        end else if (shadow_free_cnt > 0) begin
          shadow_free_cnt--;
          r.granted = shadow_free[shadow_free_cnt];
        end else if (shadow_next_fresh < lim) begin
          r.granted = ipa_pkg::IDX_W'(shadow_next_fresh);
          shadow_next_fresh++;
        end else begin
          r.status = ipa_pkg::ST_EMPTY;
        end
      end
      ipa_pkg::OP_REL_NOW: begin
        if (idx == '0 || shadow_free_cnt >= DEPTH) begin
          r.status = ipa_pkg::ST_IGNORED;
        end else begin
          shadow_free[shadow_free_cnt] = idx;
          shadow_free_cnt++;
        end
      end
      ipa_pkg::OP_REL_DEFER: begin
        if (idx == '0 || shadow_defer_cnt >= DEPTH) begin
          r.status = ipa_pkg::ST_IGNORED;
        end else begin
          shadow_deferred[shadow_defer_cnt] = idx;
          shadow_defer_cnt++;
        end
      end
      ipa_pkg::OP_FLUSH: begin
        if (shadow_defer_cnt == 0) begin
          r.status = ipa_pkg::ST_EMPTY;
        end else begin
          shadow_defer_cnt--;
          r.granted = shadow_deferred[shadow_defer_cnt];
          // popped index is still reported when the free stack has no room
          if (shadow_free_cnt >= DEPTH) begin
            r.status = ipa_pkg::ST_IGNORED;
          end else begin
            shadow_free[shadow_free_cnt] = r.granted;
            shadow_free_cnt++;
          end
        end
      end
      ipa_pkg::OP_RESET: begin
        shadow_defer_cnt  = 0;
        shadow_free_cnt   = 0;
        shadow_next_fresh = 1;
      end
      default: begin
        r.status = ipa_pkg::ST_EMPTY;
      end
    endcase
    r.def_empty = (shadow_defer_cnt == 0);
    return r;
  endfunction

  // offer one transaction, hold it until taken, then maybe leave a gap
  task automatic offer_item(input logic [ipa_pkg::OP_W-1:0] op,
                            input logic [ipa_pkg::IDX_W-1:0] idx,
                            input logic typed, input reply_t typed_reply);
    reply_t pred;
    in_valid   <= 1'b1;
    opcode     <= op;
    slot_index <= idx;
    do @(posedge clk); while (!in_ready);
    pred = predict_pool_reply(op, idx);
    pending_replies.insert(pending_replies.size(), typed ? typed_reply : pred);
    if (op == ipa_pkg::OP_RESET) begin
      held_slots.delete();
    end else if (op == ipa_pkg::OP_ALLOC && pred.granted != '0) begin
      held_slots.insert(held_slots.size(), pred.granted);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                : $urandom_range(0, 23);
    end
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_pool_limit(input logic [ipa_pkg::LIMIT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_limit = value;
  endtask

  // mostly indices we hold, sometimes anything nonzero
  function automatic logic [ipa_pkg::IDX_W-1:0] pick_release_slot();
    int                        k;
    logic [ipa_pkg::IDX_W-1:0] slot;
    if (held_slots.size() != 0 && $urandom_range(0, 9) < 8) begin
      k    = $urandom_range(0, held_slots.size() - 1);
      slot = held_slots[k];
      held_slots.delete(k);
    end else begin
      slot = ipa_pkg::IDX_W'($urandom_range(1, 4095));
    end
    return slot;
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 36) begin
      offer_item(ipa_pkg::OP_ALLOC, ipa_pkg::IDX_W'($urandom), 1'b0, '0);
    end else if (r < 56) begin
      offer_item(ipa_pkg::OP_REL_NOW, pick_release_slot(), 1'b0, '0);
    end else if (r < 74) begin
      offer_item(ipa_pkg::OP_REL_DEFER, pick_release_slot(), 1'b0, '0);
    end else if (r < 88) begin
      offer_item(ipa_pkg::OP_FLUSH, ipa_pkg::IDX_W'($urandom), 1'b0, '0);
    end else if (r < 90) begin
      offer_item(ipa_pkg::OP_RESET, ipa_pkg::IDX_W'($urandom), 1'b0, '0);
    end else if (r < 95) begin
      offer_item((r < 93) ? ipa_pkg::OP_REL_NOW : ipa_pkg::OP_REL_DEFER, '0, 1'b0, '0);
    end else begin
      offer_item(OP_SPARE_5 + ipa_pkg::OP_W'($urandom_range(0, 2)),
                 ipa_pkg::IDX_W'($urandom), 1'b0, '0);
    end
  endtask

  // output side: stall pattern changes every stretch, one long hold-off while input keeps coming
  initial begin
    int mode;
    int stretch;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(32, 160);
      repeat (stretch) begin
        @(posedge clk);
        if (long_hold_armed && result_count >= LONG_HOLD_AFTER) begin
          long_hold_armed = 1'b0;
          out_ready <= 1'b0;
          repeat (LONG_HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ~out_ready;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (pending_replies.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("unexpected result: granted %0d status %0d deferred_empty %0b",
                   granted_index, status, deferred_empty);
      end else begin
        want = pending_replies.pop_front();
        if (granted_index !== want.granted || status !== want.status ||
            deferred_empty !== want.def_empty) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("mismatch at result %0d: granted %0d/%0d status %0d/%0d %s %0b/%0b",
                     result_count, want.granted, granted_index, want.status, status,
                     "deferred_empty", want.def_empty, deferred_empty);
        end
      end
    end
  end

  initial begin
    logic [ipa_pkg::LIMIT_W-1:0] seg_limit;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    write_pool_limit(13'd4);
    for (int i = 0; i < DIR_COUNT; i++)
      offer_item(DIR_ROWS[i].op, DIR_ROWS[i].idx, DIR_ROWS[i].typed, DIR_ROWS[i].reply);

    for (int s = 0; s < SEGMENTS; s++) begin
      drain_replies();
      case (s)
        0:       seg_limit = 13'd4096;
        1:       seg_limit = 13'd1;
        2:       seg_limit = 13'd0;
        3:       seg_limit = 13'd8191;
        4:       seg_limit = 13'd2;
        5:       seg_limit = 13'd4095;
        default: seg_limit = ipa_pkg::LIMIT_W'($urandom_range(3, 300));
      endcase
      write_pool_limit(seg_limit);
      for (int j = 0; j < SEG_ITEMS; j++) begin
        if (s == 2 && j == 70)
          drain_replies();
        random_item();
      end
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      err_count++;
      $display("%0d expected results never arrived", pending_replies.size());
    end
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
